// ----- design/sdsu_pkg.sv -----
`timescale 1ns / 1ps

package sdsu_pkg;

   // Channel layout: ADC channels first, then the TDC channels
   localparam int ADC_CHANNELS = 8;
   localparam int TDC_CHANNELS = 16;
   localparam int TOTAL_CHANNELS = ADC_CHANNELS + TDC_CHANNELS;
   localparam int CHAN_W = 5;
   localparam int VAL_W = 13;
   localparam int WORD_W = 16;
   localparam int LEFT_W = 4;

   // Section marker words
   localparam logic [WORD_W-1:0] MARK_ADC    = 16'h1007;
   localparam logic [WORD_W-1:0] MARK_TDC_LO = 16'h2005;
   localparam logic [WORD_W-1:0] MARK_TDC_HI = 16'h2006;
   localparam logic [11:0] VALUE_MOD = 12'hfff;

   // Store write port
   typedef struct packed {
      logic                     en;
      logic [CHAN_W-1:0]        addr;
      logic signed [VAL_W-1:0]  data;
   } store_wr_type;

   // Store read request
   typedef struct packed {
      logic              en;
      logic [CHAN_W-1:0] addr;
   } store_rd_type;

   // Default content of a channel that was not written in this event
   function automatic logic signed [VAL_W-1:0] chan_default(input logic [CHAN_W-1:0] ch);
      int n;
      n = int'(ch);
      if (n < ADC_CHANNELS) begin
         return VAL_W'(-(n + 1));
      end
      return VAL_W'(-10 * (n - ADC_CHANNELS + 1));
   endfunction

endpackage

// ----- design/sdsu_chan_store.sv -----
`timescale 1ns / 1ps

// Channel value memory with one valid bit per entry; an entry without its
// valid bit reads as the channel default.
module sdsu_chan_store (
   input  logic                                clock,
   input  logic                                reset,
   input  sdsu_pkg::store_wr_type              wr,
   input  sdsu_pkg::store_rd_type              rd,
   input  logic                                clear,
   output logic [sdsu_pkg::CHAN_W-1:0]         rd_chan,
   output logic signed [sdsu_pkg::VAL_W-1:0]   rd_value
);
   import sdsu_pkg::*;

   logic [VAL_W-1:0]          mem [TOTAL_CHANNELS];
   logic [TOTAL_CHANNELS-1:0] valid_ff;
   logic [TOTAL_CHANNELS-1:0] valid_in;
   logic [VAL_W-1:0]          rdata_ff;
   logic                      rvalid_ff;
   logic [CHAN_W-1:0]         raddr_ff;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rdata_ff  <= mem[rd.addr];
         rvalid_ff <= valid_ff[rd.addr];
         raddr_ff  <= rd.addr;
      end
   end

   // Valid bits: set on write, all dropped by clear
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_chan  = raddr_ff;
   assign rd_value = rvalid_ff ? signed'(rdata_ff) : chan_default(raddr_ff);

   // A clear without a write leaves no entry valid
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear && !wr.en |=> valid_ff == '0)
      else $error("valid bits survive a clear");

endmodule

// ----- design/start_detector_subevent_unpacker.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Payload
// req_      in   tdata[15:0] word, tlast last_word
// rsp_      out  tdata[4:0] channel, tdata[17:5] value, tlast last
//
// One word per cycle while parsing. A word marked last starts a dump of
// 24 channel values, one per cycle through the store's read port. No word is
// taken from the last word's transfer until the dump has read its last
// channel, and for longer while results stall. The first result passes the
// store's read register and then the output register. Reset clears parse
// state and all valid bits; the stores read as their defaults at once. A
// stalled result holds the dump; the read pipeline stops without losing an entry.
module start_detector_subevent_unpacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] word
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [4:0] channel, [17:5] value, rest zero
   output logic        rsp_tlast
);
   import sdsu_pkg::*;

   typedef enum logic [1:0] {
      ST_PARSE = 2'b01,
      ST_DUMP  = 2'b10
   } state_type;

   typedef enum logic [2:0] {
      MODE_SEARCH = 3'b001,
      MODE_COUNT  = 3'b010,
      MODE_DATA   = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      SEC_ADC    = 2'd0,
      SEC_TDC_LO = 2'd1,
      SEC_TDC_HI = 2'd2
   } section_type;

   localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(TOTAL_CHANNELS - 1);

   state_type          st_ff, st_in;
   mode_type           mode_ff, mode_in;
   section_type        sec_ff, sec_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic               ended_ff, ended_in;
   logic [CHAN_W-1:0]  idx_ff, idx_in;
   logic               s1_vld_ff, s1_vld_in;
   logic               s1_last_ff, s1_last_in;
   logic               out_vld_ff, out_vld_in;
   logic               out_last_ff;
   logic [CHAN_W-1:0]  out_chan_ff;
   logic signed [VAL_W-1:0] out_val_ff;

   logic               accept;
   logic               s1_adv;
   logic               clear_store;
   store_wr_type       wr;
   store_rd_type       rd;
   logic [CHAN_W-1:0]  rd_chan;
   logic signed [VAL_W-1:0] rd_value;
   logic [2:0]         dch;
   logic [11:0]        low;
   logic [CHAN_W-1:0]  tdc_ch;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_PARSE);
   assign s1_adv = s1_vld_ff && (!out_vld_ff || rsp_tready);

   // Data word decode
   assign dch = req_tdata[14:12];
   assign low = req_tdata[11:0];
   assign tdc_ch = (sec_ff == SEC_TDC_HI) ? CHAN_W'(dch) + CHAN_W'(8) : CHAN_W'(dch);

   always_comb begin
      wr.en   = 1'b0;
      wr.addr = '0;
      wr.data = (low == VALUE_MOD) ? '0 : VAL_W'(low);
      if (accept && !ended_ff && mode_ff == MODE_DATA) begin
         if (sec_ff == SEC_ADC) begin
            wr.en   = (int'(dch) < ADC_CHANNELS);
            wr.addr = CHAN_W'(dch);
         end else begin
            wr.en   = (int'(tdc_ch) < TDC_CHANNELS);
            wr.addr = tdc_ch + CHAN_W'(ADC_CHANNELS);
         end
      end
   end

   // Parser and dump sequencer
   always_comb begin
      st_in       = st_ff;
      mode_in     = mode_ff;
      sec_in      = sec_ff;
      left_in     = left_ff;
      ended_in    = ended_ff;
      idx_in      = idx_ff;
      rd.en       = 1'b0;
      rd.addr     = idx_ff;
      clear_store = 1'b0;
      s1_vld_in   = s1_vld_ff && !s1_adv;
      s1_last_in  = s1_last_ff;
      unique case (st_ff)
         ST_PARSE: begin
            if (accept) begin
               if (!ended_ff) begin
                  unique case (mode_ff) inside
                     MODE_DATA: begin
                        if (left_ff > LEFT_W'(1)) begin
                           left_in = left_ff - LEFT_W'(1);
                        end else begin
                           left_in = '0;
                           mode_in = MODE_SEARCH;
                        end
                     end
                     MODE_COUNT, MODE_SEARCH: begin
                        if (mode_ff == MODE_COUNT && req_tdata[15]) begin
                           left_in = LEFT_W'(dch) + LEFT_W'(1);
                           mode_in = MODE_DATA;
                        end else if (req_tdata == '0) begin
                           ended_in = 1'b1;
                           mode_in  = MODE_SEARCH;
                        end else if (req_tdata == MARK_ADC) begin
                           sec_in  = SEC_ADC;
                           mode_in = MODE_COUNT;
                        end else if (req_tdata == MARK_TDC_LO) begin
                           sec_in  = SEC_TDC_LO;
                           mode_in = MODE_COUNT;
                        end else if (req_tdata == MARK_TDC_HI) begin
                           sec_in  = SEC_TDC_HI;
                           mode_in = MODE_COUNT;
                        end else begin
                           mode_in = MODE_SEARCH;
                        end
                     end
                     default: mode_in = MODE_SEARCH;
                  endcase
               end
               if (req_tlast) begin
                  mode_in  = MODE_SEARCH;
                  sec_in   = SEC_ADC;
                  left_in  = '0;
                  ended_in = 1'b0;
                  idx_in   = '0;
                  st_in    = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            if (!s1_vld_ff || s1_adv) begin
               rd.en      = 1'b1;
               s1_vld_in  = 1'b1;
               s1_last_in = (idx_ff == LAST_CHAN);
               idx_in     = idx_ff + CHAN_W'(1);
               if (idx_ff == LAST_CHAN) begin
                  clear_store = 1'b1;
                  idx_in      = '0;
                  st_in       = ST_PARSE;
               end
            end
         end
         default: st_in = ST_PARSE;
      endcase
   end

   assign out_vld_in = s1_adv || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_PARSE;
         mode_ff    <= MODE_SEARCH;
         sec_ff     <= SEC_ADC;
         left_ff    <= '0;
         ended_ff   <= 1'b0;
         idx_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         mode_ff    <= mode_in;
         sec_ff     <= sec_in;
         left_ff    <= left_in;
         ended_ff   <= ended_in;
         idx_ff     <= idx_in;
         s1_vld_ff  <= s1_vld_in;
         s1_last_ff <= s1_last_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_chan_ff <= rd_chan;
         out_val_ff  <= rd_value;
         out_last_ff <= s1_last_ff;
      end
   end

   sdsu_chan_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .clear    (clear_store),
      .rd_chan  (rd_chan),
      .rd_value (rd_value)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'd0, out_val_ff, out_chan_ff};

   // Data mode always has words outstanding, other modes none
   a_left_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DATA) == (left_ff != '0))
      else $error("word count out of step with parse mode");

   // The final result of a dump is the last channel
   a_last_chan: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_last_ff |-> out_chan_ff == LAST_CHAN)
      else $error("dump ends on the wrong channel");

   // A last word starts a dump from channel zero
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> st_ff == ST_DUMP && idx_ff == '0)
      else $error("last word did not start a dump");

endmodule

// ----- sim/subevent_dump_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the unpacker, keeps its own copy of the parse
// state and channel stores, and checks every dump value in order.
module subevent_dump_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] word
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [4:0] channel, [17:5] value, rest zero
   input  logic        rsp_tlast,
   output int          failures,
   output int          pending
);

   import sdsu_pkg::*;

   localparam int PAD_LO = CHAN_W + VAL_W;

   // Section codes
   localparam logic [1:0] SEC_ADC    = 2'd0;
   localparam logic [1:0] SEC_TDC_LO = 2'd1;
   localparam logic [1:0] SEC_TDC_HI = 2'd2;

   typedef enum logic [2:0] {
      SEEK_MARKER = 3'b001,
      AWAIT_COUNT = 3'b010,
      READ_DATA   = 3'b100
   } parse_mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0]       channel;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } chan_result_type;

   // Shadow state
   parse_mode_type          mode;
   logic [1:0]              section;
   logic [LEFT_W-1:0]       words_left;
   logic                    ended;
   logic signed [VAL_W-1:0] adc_vals [ADC_CHANNELS];
   logic signed [VAL_W-1:0] tdc_vals [TDC_CHANNELS];

   chan_result_type dump_expected_q [$];
   chan_result_type want;
   int              errs;

   // Back to the start of an event: parse state cleared, stores at defaults
   task automatic restore_event_state();
      int i;
      mode       = SEEK_MARKER;
      section    = SEC_ADC;
      words_left = '0;
      ended      = 1'b0;
      for (i = 0; i < ADC_CHANNELS; i++) begin
         adc_vals[i] = VAL_W'(-(i + 1));
      end
      for (i = 0; i < TDC_CHANNELS; i++) begin
         tdc_vals[i] = VAL_W'(-10 * (i + 1));
      end
   endtask

   // A word seen while searching: zero end, a marker, or nothing
   task automatic examine_word(input logic [15:0] w);
      if (w == 16'h0000) begin
         ended = 1'b1;
         mode  = SEEK_MARKER;
      end else if (w == MARK_ADC) begin
         section = SEC_ADC;
         mode    = AWAIT_COUNT;
      end else if (w == MARK_TDC_LO) begin
         section = SEC_TDC_LO;
         mode    = AWAIT_COUNT;
      end else if (w == MARK_TDC_HI) begin
         section = SEC_TDC_HI;
         mode    = AWAIT_COUNT;
      end else begin
         mode = SEEK_MARKER;
      end
   endtask

   task automatic store_data(input logic [15:0] w);
      int                      idx;
      logic signed [VAL_W-1:0] v;
      idx = int'(w[14:12]);
      // low 12 bits mod 0xfff: only 0xfff itself folds to zero
      if (w[11:0] == VALUE_MOD) begin
         v = '0;
      end else begin
         v = $signed({1'b0, w[11:0]});
      end
      if (section == SEC_ADC) begin
         if (idx < ADC_CHANNELS) adc_vals[idx] = v;
      end else begin
         if (section == SEC_TDC_HI) idx += 8;
         if (idx < TDC_CHANNELS) tdc_vals[idx] = v;
      end
   endtask

   // One accepted word; a last word queues the whole dump
   task automatic absorb_word(input logic [15:0] w, input logic last_word);
      chan_result_type r;
      int              i;
      if (!ended) begin
         unique case (mode)
            READ_DATA: begin
               store_data(w);
               if (words_left > 0) words_left = words_left - 1'b1;
               if (words_left == 0) mode = SEEK_MARKER;
            end
            AWAIT_COUNT: begin
               if (w[15]) begin
                  words_left = {1'b0, w[14:12]} + 4'd1;
                  mode       = READ_DATA;
               end else begin
                  examine_word(w);
               end
            end
            default: begin
               examine_word(w);
            end
         endcase
      end
      if (last_word) begin
         for (i = 0; i < TOTAL_CHANNELS; i++) begin
            r.channel = CHAN_W'(i);
            if (i < ADC_CHANNELS) begin
               r.value = adc_vals[i];
            end else begin
               r.value = tdc_vals[i - ADC_CHANNELS];
            end
            r.last = (i == TOTAL_CHANNELS - 1);
            dump_expected_q.push_back(r);
         end
         restore_event_state();
      end
   endtask

   // Results are checked before words so a same-edge transfer cannot mask a stray one
   always @(posedge clock) begin
      errs = 0;
      if (reset) begin
         restore_event_state();
         dump_expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (dump_expected_q.size() == 0) begin
               $error("unexpected result: channel %0d value %0d last %0b",
                  rsp_tdata[CHAN_W-1:0], $signed(rsp_tdata[CHAN_W +: VAL_W]), rsp_tlast);
               errs++;
            end else begin
               want = dump_expected_q.pop_front();
               if (rsp_tdata[CHAN_W-1:0] !== want.channel) begin
                  $error("channel: expected %0d, actual %0d",
                     want.channel, rsp_tdata[CHAN_W-1:0]);
                  errs++;
               end
               if (rsp_tdata[CHAN_W +: VAL_W] !== want.value) begin
                  $error("value: expected %0d, actual %0d",
                     want.value, $signed(rsp_tdata[CHAN_W +: VAL_W]));
                  errs++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
                  errs++;
               end
               if (rsp_tdata[23:PAD_LO] !== '0) begin
                  $error("pad: expected 0, actual %0h", rsp_tdata[23:PAD_LO]);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_word(req_tdata, req_tlast);
         end
      end
      failures <= failures + errs;
      pending  <= dump_expected_q.size();
   end

endmodule

// ----- sim/start_detector_subevent_unpacker_tb.sv -----
`timescale 1ns / 1ps

module start_detector_subevent_unpacker_tb;

   import sdsu_pkg::*;

   localparam int IDLE_PCT    = 28;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] word
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;    // [4:0] channel, [17:5] value, rest zero
   logic        rsp_tlast;

   int mismatch_count;
   int results_pending;
   int words_sent  = 0;
   int quiet_count = 0;
   int stall_asks  = 0;
   int asks_seen   = 0;
   int hold_left   = 0;
   bit calm        = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   start_detector_subevent_unpacker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   subevent_dump_checker dump_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .failures   (mismatch_count),
      .pending    (results_pending)
   );

   // Result side: random back-pressure, a long hold-off on request
   always @(posedge clock) begin
      if (asks_seen != stall_asks) begin
         asks_seen  <= stall_asks;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_count <= 0;
         end else if (quiet_count >= QUIET_LIMIT) begin
            $display("start_detector_subevent_unpacker_tb failed");
            $finish;
         end else begin
            quiet_count <= quiet_count + 1;
         end
      end
   end

   // Offer one word, with random idle cycles ahead of it; returns on the transfer edge
   task automatic offer_word(input logic [15:0] w, input logic last_word);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= last_word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Sender pause until every queued dump value has been seen
   task automatic wait_for_dump_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_marker();
      logic [15:0] m;
      case ($urandom_range(0, 2))
         0:       m = MARK_ADC;
         1:       m = MARK_TDC_LO;
         default: m = MARK_TDC_HI;
      endcase
      return m;
   endfunction

   // Data word with random channel; folding and zero values get extra weight
   function automatic logic [15:0] data_word();
      logic [15:0] w;
      w = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         w[11:0] = VALUE_MOD;
      end else if ($urandom_range(0, 15) == 0) begin
         w[11:0] = 12'h000;
      end
      return w;
   endfunction

   // Anything at all, markers and zero words included
   function automatic logic [15:0] noise_word();
      logic [15:0] w;
      case ($urandom_range(0, 9)) inside
         0, 1:    w = pick_marker();
         2:       w = 16'h0000;
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   // Mostly well-formed sections with random content, some broken or noisy
   task automatic send_random_subevent();
      logic [15:0] words [$];
      logic [15:0] w;
      int          sections;
      int          s;
      int          k;
      int          pick;
      int          n_data;
      int          n_sent;
      sections = $urandom_range(0, 4);
      for (s = 0; s < sections; s++) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            words.push_back(pick_marker());
            n_data = $urandom_range(0, 7);
            w      = 16'($urandom);
            w[15]    = 1'b1;
            w[14:12] = n_data[2:0];
            words.push_back(w);
            // now and then a section cut short
            if ($urandom_range(0, 9) == 0) begin
               n_sent = $urandom_range(0, n_data);
            end else begin
               n_sent = n_data + 1;
            end
            for (k = 0; k < n_sent; k++) words.push_back(data_word());
         end else if (pick < 82) begin
            // marker whose count word is missing
            words.push_back(pick_marker());
            w     = noise_word();
            w[15] = 1'b0;
            words.push_back(w);
         end else if (pick < 92) begin
            words.push_back(noise_word());
         end else begin
            // zero word ends parsing; the rest is ignored
            words.push_back(16'h0000);
            n_sent = $urandom_range(0, 3);
            for (k = 0; k < n_sent; k++) words.push_back(noise_word());
         end
      end
      if (words.size() == 0 || $urandom_range(0, 1) == 1) words.push_back(noise_word());
      for (k = 0; k < words.size(); k++) begin
         offer_word(words[k], k == words.size() - 1);
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full ADC section of one word, value 0xfff folds to zero
      offer_word(MARK_ADC, 1'b0);
      offer_word(16'h8000, 1'b0);
      offer_word(16'h7fff, 1'b0);
      // TDC low half, four words: top value, zero word in data, bit 15 set
      offer_word(MARK_TDC_LO, 1'b0);
      offer_word(16'hb000, 1'b0);
      offer_word(16'h0abc, 1'b0);
      offer_word(16'h1ffe, 1'b0);
      offer_word(16'h0000, 1'b0);
      offer_word(16'hf123, 1'b0);
      // Count word missing: plain word, then another marker
      offer_word(MARK_TDC_HI, 1'b0);
      offer_word(16'h1234, 1'b0);
      offer_word(MARK_TDC_HI, 1'b0);
      offer_word(MARK_ADC, 1'b0);
      offer_word(16'h8000, 1'b0);
      offer_word(16'h3456, 1'b0);
      // Count word missing and zero instead; words after the end are ignored
      offer_word(MARK_TDC_LO, 1'b0);
      offer_word(16'h0000, 1'b0);
      offer_word(16'hffff, 1'b0);
      offer_word(MARK_ADC, 1'b0);
      offer_word(16'hffff, 1'b1);
      // Lone last word dumps the defaults
      offer_word(16'hffff, 1'b1);
      // Last flag on a data word of the TDC high half
      offer_word(MARK_TDC_HI, 1'b0);
      offer_word(16'h9000, 1'b0);
      offer_word(16'h7ffe, 1'b0);
      offer_word(16'h0001, 1'b1);
      wait_for_dump_drain();

      // Random, with a long result hold-off at the start
      stall_asks <= stall_asks + 1;
      while (words_sent < 140) send_random_subevent();
      wait_for_dump_drain();

      // Stretch with no idling on either side
      calm <= 1'b1;
      while (words_sent < 260) send_random_subevent();
      calm <= 1'b0;

      while (words_sent < 370) send_random_subevent();
      wait_for_dump_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("start_detector_subevent_unpacker_tb passed");
      end else begin
         $display("start_detector_subevent_unpacker_tb failed");
      end
      $finish;
   end

endmodule
